FILE: hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants, types and tables of the tone/noise sound generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

   localparam int NUM_CHAN  = 4;
   localparam int NUM_REGS  = 8;
   localparam int CHAN_AW   = $clog2(NUM_CHAN);
   localparam int REG_AW    = $clog2(NUM_REGS);

   localparam int STEP_W    = 16;
   localparam int REG_W     = 10;
   localparam int LEVEL_W   = 13;
   localparam int HALF_W    = 28;
   localparam int PHASE_W   = 30;
   localparam int WORK_W    = 32;
   localparam int LEFT_W    = 17;
   localparam int SPAN_W    = 29;
   localparam int LEN_W     = 12;
   localparam int SAMPLE_W  = 15;
   localparam int NOISE_W   = 17;
   localparam int MPROD_W   = 46;
   localparam int ACC_W     = 48;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   // sub-sample resolution, a power of two
   localparam int SUB_W     = 16;
   localparam int SUB_STEP  = 1 << SUB_W;
   localparam int MAX_BATCH = 4096;

   localparam logic [SAMPLE_W-1:0] SAMPLE_CLAMP = 15'h47ff;
   localparam logic [NOISE_W-1:0]  FB_WHITE     = 17'h14002;
   localparam logic [NOISE_W-1:0]  FB_PERIODIC  = 17'h08000;
   localparam logic [NOISE_W-1:0]  NOISE_PRESET = 17'h00f35;
   localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd12905;

   // noise feedback modes
   localparam logic [1:0] NMODE_NONE     = 2'd0;
   localparam logic [1:0] NMODE_PERIODIC = 2'd1;
   localparam logic [1:0] NMODE_WHITE    = 2'd2;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // chip register indexes
   localparam logic [REG_AW-1:0] REG_TONE0 = 3'd0;
   localparam logic [REG_AW-1:0] REG_TONE1 = 3'd2;
   localparam logic [REG_AW-1:0] REG_TONE2 = 3'd4;
   localparam logic [REG_AW-1:0] REG_NOISE = 3'd6;

   localparam logic [CHAN_AW-1:0] CH_TONE2 = 2'd2;
   localparam logic [CHAN_AW-1:0] CH_NOISE = 2'd3;

   // csr register index
   localparam logic CSR_UPDATE_STEP = 1'b0;

   typedef struct packed {
      logic               wave;
      logic [PHASE_W-1:0] phase;
      logic [HALF_W-1:0]  half;
      logic [LEVEL_W-1:0] level;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

   function automatic chan_entry_type reset_entry(input logic [CHAN_AW-1:0] idx);
      chan_entry_type e;
      e.wave  = (idx == CH_NOISE) ? NOISE_PRESET[0] : 1'b0;
      e.phase = PHASE_W'(STEP_RESET);
      e.half  = HALF_W'(STEP_RESET);
      e.level = '0;
      return e;
   endfunction

   // 2 dB attenuation steps, last entry silent
   function automatic logic [LEVEL_W-1:0] level_lookup(input logic [3:0] att);
      logic [LEVEL_W-1:0] lv;
      case (att)
         4'd0:    lv = 13'd6143;
         4'd1:    lv = 13'd4879;
         4'd2:    lv = 13'd3875;
         4'd3:    lv = 13'd3078;
         4'd4:    lv = 13'd2445;
         4'd5:    lv = 13'd1942;
         4'd6:    lv = 13'd1543;
         4'd7:    lv = 13'd1225;
         4'd8:    lv = 13'd973;
         4'd9:    lv = 13'd773;
         4'd10:   lv = 13'd614;
         4'd11:   lv = 13'd487;
         4'd12:   lv = 13'd387;
         4'd13:   lv = 13'd307;
         4'd14:   lv = 13'd244;
         default: lv = 13'd0;
      endcase
      return lv;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/psg_if.sv
// ----------------------------------------------------------------------------
// psg_req_if / psg_rsp_if
// Valid/ready channels carrying requests and mixed samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_req_if import psg_pkg::*;;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [7:0]        data;
   logic              batch_start;
   logic [LEN_W-1:0]  batch_length;

   modport source (output valid, req_type, data, batch_start, batch_length, input ready);
   modport sink   (input valid, req_type, data, batch_start, batch_length, output ready);
endinterface

interface psg_rsp_if import psg_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psg_ram.sv
// ----------------------------------------------------------------------------
// psg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/psg_tone_noise_mixer.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_mixer
// Three square-wave tones plus an LFSR noise channel, mixed to one sample.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      carries
//  req_chan  in   valid/ready    req_type, data, batch_start, batch_length
//  rsp_chan  out  valid/ready    sample (one per tick request)
//  csr_*     in   APB write/read update_step at byte address 0
//
//  Write request: states S_WMUL and S_WWB, plus S_WN3 when the noise half
//  period is reloaded. Tick request: after the accept, each channel in turn
//  is read from the shared channel RAM (S_TRD), loaded (S_TLD), run through
//  its edge loop (S_TRUN), written back and multiplied (S_TMUL) and
//  accumulated (S_TACC); S_DONE then clamps and delivers the result.
//  Reset: synchronous; per-channel valid bits stand in for the RAM contents,
//  so no clearing pass is needed.
//  A finished sample waits in the output register; the next request is taken
//  meanwhile and only a following sample stalls on it.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone_noise_mixer import psg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   psg_req_if.sink                req_chan,
   psg_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_WMUL = 10'b0000000010,  // period product, read target entry
      S_WWB  = 10'b0000000100,  // write back target entry, or noise half period calc
      S_WN3  = 10'b0000001000,  // write back noise half period
      S_TRD  = 10'b0000010000,  // read channel entry
      S_TLD  = 10'b0000100000,  // load working regs, batch catch-up
      S_TRUN = 10'b0001000000,  // step through wave edges or noise shifts
      S_TMUL = 10'b0010000000,  // write back, high time * level
      S_TACC = 10'b0100000000,  // accumulate
      S_DONE = 10'b1000000000   // clamp and hand to output register
   } state_type;

   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SAMPLE_CLAMP) << SUB_W;
   localparam logic [LEFT_W-1:0] SUB_LEFT = LEFT_W'(SUB_STEP);
   localparam logic [LEN_W:0] BATCH_CAP = (MAX_BATCH > (1 << LEN_W)) ?
                                          (LEN_W+1)'(1 << LEN_W) : (LEN_W+1)'(MAX_BATCH);

   state_type                  state_ff, state_in;
   logic [REG_W-1:0]           regs_ff [NUM_REGS];
   logic [REG_W-1:0]           regs_in [NUM_REGS];
   logic [REG_AW-1:0]          latched_ff, latched_in;
   logic [REG_AW-1:0]          r_ff, r_in;
   logic [3:0]                 dat_ff, dat_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [NOISE_W-1:0]         nshift_ff, nshift_in;
   logic [1:0]                 nmode_ff, nmode_in;
   logic [STEP_W+REG_W-1:0]    prod_ff, prod_in;
   logic [HALF_W-1:0]          h3_ff, h3_in;
   logic [CHAN_AW-1:0]         ch_ff, ch_in;
   logic [SPAN_W-1:0]          span_ff, span_in;
   logic signed [WORK_W-1:0]   ph_ff, ph_in;
   logic [HALF_W-1:0]          hp_ff, hp_in;
   logic                       w_ff, w_in;
   logic [LEVEL_W-1:0]         lvl_ff, lvl_in;
   logic signed [WORK_W-1:0]   v_ff, v_in;
   logic [LEFT_W-1:0]          left_ff, left_in;
   logic signed [MPROD_W-1:0]  mprod_ff, mprod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]        out_sample_ff, out_sample_in;
   logic [NUM_CHAN-1:0]        valid_ff, valid_in;
   logic [CHAN_AW-1:0]         rd_addr_ff;

   // channel state RAM
   logic                       ram_we, ram_re;
   logic [CHAN_AW-1:0]         ram_waddr, ram_raddr;
   chan_entry_type             ram_wdata, ram_rdata, rd_entry;

   psg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHAN)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // never-written entries read as their reset value
   assign rd_entry = valid_ff[rd_addr_ff] ? ram_rdata : reset_entry(rd_addr_ff);

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.sample = out_sample_ff;

   // config port
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_UPDATE_STEP) ? CSR_DW'(step_ff) : '0;

   // helper values
   logic [STEP_W-1:0]   eff_step;
   logic [NOISE_W-1:0]  fb_mask, nshift_next;
   logic [LEN_W:0]      len_cap;
   logic [2:0]          req_r;
   logic [REG_W-1:0]    req_regval;
   logic [PHASE_W-1:0]  ld_cnt;
   logic [HALF_W-1:0]   new_half;
   logic signed [WORK_W-1:0] hp_s, ph_step1, ph_step2;
   logic [PHASE_W-1:0]  cnt_u;
   logic signed [MPROD_W-1:0] v_ext, lvl_ext;

   assign eff_step = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign fb_mask  = (nmode_ff == NMODE_WHITE)    ? FB_WHITE :
                     (nmode_ff == NMODE_PERIODIC) ? FB_PERIODIC : '0;
   assign nshift_next = (nshift_ff[0] ? (nshift_ff ^ fb_mask) : nshift_ff) >> 1;
   assign len_cap  = ({1'b0, req_chan.batch_length} > BATCH_CAP) ?
                     BATCH_CAP : {1'b0, req_chan.batch_length};
   assign new_half = (prod_ff == '0) ? HALF_W'(eff_step) : HALF_W'(prod_ff);
   assign hp_s     = $signed(WORK_W'(hp_ff));
   assign ph_step1 = ph_ff + hp_s;
   assign ph_step2 = ph_step1 + hp_s;
   assign cnt_u    = ph_ff[PHASE_W-1:0];
   assign v_ext    = MPROD_W'(v_ff);
   assign lvl_ext  = $signed(MPROD_W'(lvl_ff));
   assign ld_cnt   = rd_entry.phase +
                     (((rd_entry.level == '0) && (SPAN_W'(rd_entry.phase) <= span_ff)) ?
                      PHASE_W'(span_ff) : '0);

   // register decode of the incoming byte
   always_comb begin
      if (req_chan.data[7]) begin
         req_r      = req_chan.data[6:4];
         req_regval = {regs_ff[req_chan.data[6:4]][REG_W-1:4], req_chan.data[3:0]};
      end else begin
         req_r = latched_ff;
         if (latched_ff == REG_TONE0 || latched_ff == REG_TONE1 ||
             latched_ff == REG_TONE2) begin
            req_regval = {req_chan.data[5:0], regs_ff[latched_ff][3:0]};
         end else begin
            req_regval = {regs_ff[latched_ff][REG_W-1:4], req_chan.data[3:0]};
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      regs_in       = regs_ff;
      latched_in    = latched_ff;
      r_in          = r_ff;
      dat_in        = dat_ff;
      step_in       = step_ff;
      nshift_in     = nshift_ff;
      nmode_in      = nmode_ff;
      prod_in       = prod_ff;
      h3_in         = h3_ff;
      ch_in         = ch_ff;
      span_in       = span_ff;
      ph_in         = ph_ff;
      hp_in         = hp_ff;
      w_in          = w_ff;
      lvl_in        = lvl_ff;
      v_in          = v_ff;
      left_in       = left_ff;
      mprod_in      = mprod_ff;
      acc_in        = acc_ff;
      valid_in      = valid_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_sample_in = out_sample_ff;
      ram_we        = 1'b0;
      ram_waddr     = ch_ff;
      ram_wdata     = rd_entry;
      ram_re        = 1'b0;
      ram_raddr     = ch_ff;

      if (csr_wr && csr_paddr[2] == CSR_UPDATE_STEP) begin
         step_in = csr_pwdata[STEP_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.req_type == REQ_WRITE) begin
                  regs_in[req_r] = req_regval;
                  latched_in     = req_r;
                  r_in           = req_r;
                  dat_in         = req_chan.data[3:0];
                  if (req_r == REG_NOISE) begin
                     nmode_in  = req_regval[2] ? NMODE_WHITE : NMODE_PERIODIC;
                     nshift_in = NOISE_PRESET;
                  end
                  state_in = S_WMUL;
               end else begin
                  span_in  = req_chan.batch_start ?
                             SPAN_W'({len_cap, SUB_W'(0)}) : '0;
                  ch_in    = '0;
                  acc_in   = '0;
                  state_in = S_TRD;
               end
            end
         end
         S_WMUL: begin
            prod_in   = eff_step * regs_ff[r_ff];
            ram_re    = 1'b1;
            ram_raddr = (r_ff == REG_NOISE) ? CH_TONE2 : r_ff[2:1];
            state_in  = S_WWB;
         end
         S_WWB: begin
            ram_waddr = r_ff[2:1];
            if (r_ff == REG_NOISE) begin
               // noise rate three tracks twice the tone 2 half period
               h3_in = (regs_ff[REG_NOISE][1:0] == 2'd3) ? (rd_entry.half << 1) :
                       (HALF_W'(eff_step) << (3'd5 + {1'b0, regs_ff[REG_NOISE][1:0]}));
               ram_re    = 1'b1;
               ram_raddr = CH_NOISE;
               state_in  = S_WN3;
            end else if (!r_ff[0]) begin
               ram_we         = 1'b1;
               ram_wdata.half = new_half;
               valid_in[r_ff[2:1]] = 1'b1;
               if (r_ff == REG_TONE2 && regs_ff[REG_NOISE][1:0] == 2'd3) begin
                  h3_in     = new_half << 1;
                  ram_re    = 1'b1;
                  ram_raddr = CH_NOISE;
                  state_in  = S_WN3;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               ram_we          = 1'b1;
               ram_wdata.level = level_lookup(dat_ff);
               valid_in[r_ff[2:1]] = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_WN3: begin
            ram_we         = 1'b1;
            ram_waddr      = CH_NOISE;
            ram_wdata.half = h3_ff;
            if (r_ff == REG_NOISE) begin
               ram_wdata.wave = NOISE_PRESET[0];
            end
            valid_in[CH_NOISE] = 1'b1;
            state_in       = S_IDLE;
         end
         S_TRD: begin
            ram_re   = 1'b1;
            state_in = S_TLD;
         end
         S_TLD: begin
            hp_in  = rd_entry.half;
            w_in   = rd_entry.wave;
            lvl_in = rd_entry.level;
            if (ch_ff != CH_NOISE) begin
               v_in  = rd_entry.wave ? $signed(WORK_W'(ld_cnt)) : '0;
               ph_in = $signed(WORK_W'(ld_cnt)) - $signed(WORK_W'(SUB_STEP));
            end else begin
               v_in    = '0;
               ph_in   = $signed(WORK_W'(ld_cnt));
               left_in = SUB_LEFT;
            end
            state_in = S_TRUN;
         end
         S_TRUN: begin
            if (ch_ff != CH_NOISE) begin
               if (ph_ff > 0) begin
                  v_in     = v_ff - (w_ff ? ph_ff : '0);
                  state_in = S_TMUL;
               end else if (ph_step1 > 0) begin
                  ph_in = ph_step1;
                  w_in  = !w_ff;
                  v_in  = v_ff + (!w_ff ? hp_s : '0);
               end else begin
                  ph_in = ph_step2;
                  v_in  = v_ff + hp_s;
               end
            end else begin
               if (left_ff == '0) begin
                  state_in = S_TMUL;
               end else if (cnt_u < PHASE_W'(left_ff)) begin
                  // edge inside the remaining span
                  v_in      = v_ff + (w_ff ? ph_ff : '0);
                  left_in   = left_ff - LEFT_W'(cnt_u);
                  nshift_in = nshift_next;
                  w_in      = nshift_next[0];
                  ph_in     = hp_s;
               end else begin
                  v_in    = v_ff + (w_ff ? $signed(WORK_W'(left_ff)) : '0);
                  left_in = '0;
                  if (cnt_u == PHASE_W'(left_ff)) begin
                     nshift_in = nshift_next;
                     w_in      = nshift_next[0];
                     ph_in     = hp_s;
                  end else begin
                     ph_in = ph_ff - $signed(WORK_W'(left_ff));
                  end
               end
            end
         end
         S_TMUL: begin
            ram_we          = 1'b1;
            ram_wdata.wave  = w_ff;
            ram_wdata.phase = ph_ff[PHASE_W-1:0];
            ram_wdata.half  = hp_ff;
            ram_wdata.level = lvl_ff;
            valid_in[ch_ff] = 1'b1;
            mprod_in        = v_ext * lvl_ext;
            state_in        = S_TACC;
         end
         S_TACC: begin
            acc_in = acc_ff + ACC_W'(mprod_ff);
            if (ch_ff == CH_NOISE) begin
               state_in = S_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_TRD;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               // negative mix counts as overflow
               out_sample_in = (acc_ff < 0 || acc_ff > ACC_MAX) ?
                               SAMPLE_CLAMP : acc_ff[SUB_W +: SAMPLE_W];
               out_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         latched_ff   <= '0;
         step_ff      <= STEP_RESET;
         nshift_ff    <= NOISE_PRESET;
         nmode_ff     <= NMODE_NONE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= (i % 2 == 1) ? REG_W'(15) : '0;
         end
      end else begin
         state_ff     <= state_in;
         latched_ff   <= latched_in;
         step_ff      <= step_in;
         nshift_ff    <= nshift_in;
         nmode_ff     <= nmode_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff          <= r_in;
      dat_ff        <= dat_in;
      prod_ff       <= prod_in;
      h3_ff         <= h3_in;
      ch_ff         <= ch_in;
      span_ff       <= span_in;
      ph_ff         <= ph_in;
      hp_ff         <= hp_in;
      w_ff          <= w_in;
      lvl_ff        <= lvl_in;
      v_ff          <= v_in;
      left_ff       <= left_in;
      mprod_ff      <= mprod_in;
      acc_ff        <= acc_in;
      out_sample_ff <= out_sample_in;
      if (ram_re) begin
         rd_addr_ff <= ram_raddr;
      end
   end

   // a delivered sample never exceeds the clamp value
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_sample_ff <= SAMPLE_CLAMP)
      else $error("sample above clamp");

   // the tone/noise count written back is always positive
   a_phase_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TMUL |-> ph_ff > 0)
      else $error("non-positive phase written back");

   // the noise span left never grows past one sample
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TRUN && ch_ff == CH_NOISE |-> left_ff <= SUB_LEFT)
      else $error("noise span out of range");

   // a waiting sample is not overwritten by the next one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && out_valid_ff && !rsp_chan.ready |=> state_ff == S_DONE)
      else $error("result overwritten");

endmodule

`default_nettype wire
